// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL. Each use expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PMC_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// The consequent must hold in the cycle after the antecedent.
`define PMC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

// The expression must never be true.
`define PMC_ASSERT_NEVER(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`endif

// ----- hw/rtl/pmc_pkg.sv -----
package pmc_pkg;

    localparam int RAND_W  = 15;
    localparam int COORD_W = 5;
    localparam int SIZE_W  = 8;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_STEP  = 1'b1;

    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_RIGHT = 2'd3;

    typedef struct packed {
        logic              action;
        logic [RAND_W-1:0] pick_random;
        logic [RAND_W-1:0] direction_random;
    } pmc_cmd_t;

    typedef struct packed {
        logic               carved;
        logic               removed;
        logic               done_res;
        logic [COORD_W-1:0] cell_x;
        logic [COORD_W-1:0] cell_y;
        logic [COORD_W-1:0] wall_x;
        logic [COORD_W-1:0] wall_y;
        logic [SIZE_W-1:0]  frontier_size;
    } pmc_res_t;

    typedef struct packed {
        logic busy;
        logic done;
    } pmc_div_stat_t;

endpackage

// ----- hw/rtl/pmc_cmd_if.sv -----
interface pmc_cmd_if;
    import pmc_pkg::*;

    logic     valid;
    logic     ready;
    pmc_cmd_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/pmc_res_if.sv -----
interface pmc_res_if;
    import pmc_pkg::*;

    logic     valid;
    logic     ready;
    pmc_res_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/pmc_mod_unit.sv -----
`include "assert_macros.svh"

module pmc_mod_unit #(
    parameter int DIVISOR_W = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [pmc_pkg::RAND_W-1:0]   dividend,
    input  logic [DIVISOR_W-1:0]         divisor,
    output pmc_pkg::pmc_div_stat_t       stat,
    output logic [DIVISOR_W-1:0]         remainder
);
    import pmc_pkg::*;

    localparam int STEP_W = $clog2(RAND_W);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(RAND_W - 1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic [RAND_W-1:0]    dvd_reg;
    logic [DIVISOR_W-1:0] dsr_reg;
    logic [DIVISOR_W-1:0] rem_reg;

    logic [DIVISOR_W:0]   trial;
    logic                 trial_ge;
    logic [DIVISOR_W-1:0] rem_step;

    // Restoring remainder: one dividend bit is brought down per cycle.
    always_comb
    begin
        trial    = {rem_reg, dvd_reg[RAND_W-1]};
        trial_ge = (trial >= {1'b0, dsr_reg});
        if (trial_ge)
        begin
            rem_step = DIVISOR_W'(trial - {1'b0, dsr_reg});
        end
        else
        begin
            rem_step = trial[DIVISOR_W-1:0];
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
        end
        else if (busy_reg)
        begin
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[RAND_W-2:0], 1'b0};
            rem_reg <= rem_step;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign remainder = rem_reg;

    `PMC_ASSERT_IMPLIES(a_rem_below_divisor, done_reg, rem_reg < dsr_reg)
    `PMC_ASSERT_NEVER(a_no_restart_busy, start && busy_reg)
    `PMC_ASSERT_NEXT(a_done_after_last, busy_reg && !start && step_reg == STEP_LAST, done_reg)

endmodule

// ----- hw/rtl/prim_maze_carver.sv -----
// Randomized Prim maze carver over a grid of ((GRID_SIDE-1)/2)^2 cells (15 x 15 by default).
// Each transaction on cmd returns exactly one transaction on res, and cmd is ready only
// while the block is idle. A start item sweeps the visited store one entry per cycle. A
// step first takes a remainder of pick_random by the list size in a shared restoring
// unit, reads the picked entry and probes the four neighbours through the visited
// store's read port. A carve then takes a second remainder for the direction in the
// same unit; a removal shifts the later list entries down through the list's read and
// write ports at one entry per cycle. A step on an empty list answers with done_res set
// and no remainder. A finished result waits in an output register, so the next
// transaction may be accepted before res is taken.
`include "assert_macros.svh"

module prim_maze_carver #(
    parameter int GRID_SIDE = 31
) (
    input  logic       clk,
    input  logic       rst_n,
    pmc_cmd_if.sink    cmd,
    pmc_res_if.source  res
);
    import pmc_pkg::*;

    localparam int SIDE_CELLS = (GRID_SIDE - 1) / 2;
    localparam int CELL_TOTAL = SIDE_CELLS * SIDE_CELLS;
    localparam int CW         = $clog2(SIDE_CELLS);
    localparam int EW         = 2 * CW;
    localparam int AW         = $clog2(CELL_TOTAL);
    localparam int CNT_W      = $clog2(CELL_TOTAL + 1);
    localparam int CX_W       = CW + 3;

    localparam logic [CW-1:0]    SIDE_LAST = CW'(SIDE_CELLS - 1);
    localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(CELL_TOTAL);
    localparam logic [2:0]       SCAN_END  = 3'd4;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_CLEAR   = 4'd1;
    localparam logic [3:0] S_PICK    = 4'd2;
    localparam logic [3:0] S_LIST_RD = 4'd3;
    localparam logic [3:0] S_CELL    = 4'd4;
    localparam logic [3:0] S_SCAN    = 4'd5;
    localparam logic [3:0] S_DIR     = 4'd6;
    localparam logic [3:0] S_CARVE   = 4'd7;
    localparam logic [3:0] S_SHIFT   = 4'd8;
    localparam logic [3:0] S_EMIT    = 4'd9;

    typedef struct packed {
        logic          inb;
        logic [CW-1:0] ny;
        logic [CW-1:0] nx;
    } nb_t;

    function automatic nb_t nb_calc(input logic [CW-1:0] cx, input logic [CW-1:0] cy,
                                    input logic [1:0] dir);
        nb_t r;
        r.inb = 1'b1;
        r.nx  = cx;
        r.ny  = cy;
        case (dir)
            DIR_UP:
            begin
                r.inb = (cy != '0);
                r.ny  = cy - 1'b1;
            end
            DIR_DOWN:
            begin
                r.inb = (cy != SIDE_LAST);
                r.ny  = cy + 1'b1;
            end
            DIR_LEFT:
            begin
                r.inb = (cx != '0);
                r.nx  = cx - 1'b1;
            end
            DIR_RIGHT:
            begin
                r.inb = (cx != SIDE_LAST);
                r.nx  = cx + 1'b1;
            end
            default:
            begin
                r.inb = 1'b0;
            end
        endcase
        return r;
    endfunction

    function automatic logic [AW-1:0] vis_addr(input logic [CW-1:0] cx,
                                               input logic [CW-1:0] cy);
        return AW'(AW'(cy) * AW'(SIDE_CELLS) + AW'(cx));
    endfunction

    // Control state
    logic [3:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              res_valid_reg, res_valid_next;

    // Working registers
    logic [RAND_W-1:0] r2_reg, r2_next;
    logic [AW-1:0]     pick_reg, pick_next;
    logic [CW-1:0]     ci_reg, ci_next;
    logic [CW-1:0]     cj_reg, cj_next;
    logic [2:0]        scan_reg, scan_next;
    logic              inb_prev_reg, inb_prev_next;
    logic [3:0]        open_reg, open_next;
    logic [AW-1:0]     clr_reg, clr_next;
    logic [CNT_W-1:0]  shift_rd_reg, shift_rd_next;
    logic [AW-1:0]     shift_wa_reg, shift_wa_next;
    logic              shift_wv_reg, shift_wv_next;
    pmc_res_t          pend_reg, pend_next;
    pmc_res_t          res_data_reg, res_data_next;

    // Frontier list memory
    logic [EW-1:0]     list_mem [CELL_TOTAL];
    logic              list_we;
    logic [AW-1:0]     list_waddr;
    logic [EW-1:0]     list_wdata;
    logic [AW-1:0]     list_raddr;
    logic [EW-1:0]     list_rdata_reg;

    // Visited store
    logic              vis_mem [CELL_TOTAL];
    logic              vis_we;
    logic [AW-1:0]     vis_waddr;
    logic              vis_wdata;
    logic [AW-1:0]     vis_raddr;
    logic              vis_rdata_reg;

    // Shared remainder unit
    logic              div_start;
    logic [RAND_W-1:0] div_dividend;
    logic [CNT_W-1:0]  div_divisor;
    pmc_div_stat_t     div_stat;
    logic [CNT_W-1:0]  div_rem;

    nb_t               scan_nb;
    nb_t               carve_nb;
    logic [1:0]        carve_dir;
    logic [CX_W-1:0]   carve_cx, carve_cy, carve_wx, carve_wy;
    logic [1:0]        scan_prev;

    pmc_mod_unit #(
        .DIVISOR_W (CNT_W)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .stat      (div_stat),
        .remainder (div_rem)
    );

    always_comb
    begin
        scan_nb   = nb_calc(ci_reg, cj_reg, scan_reg[1:0]);
        scan_prev = 2'(scan_reg - 1'b1);
    end

    // The direction is the remainder-th open neighbour in up, down, left, right order.
    always_comb
    begin
        logic [1:0] seen;
        seen      = '0;
        carve_dir = DIR_UP;
        for (int k = 0; k < 4; k++)
        begin
            if (open_reg[k])
            begin
                if (seen == div_rem[1:0])
                begin
                    carve_dir = 2'(k);
                end
                seen = seen + 1'b1;
            end
        end
        carve_nb = nb_calc(ci_reg, cj_reg, carve_dir);
        carve_cx = (CX_W'(carve_nb.nx) << 1) + CX_W'(2);
        carve_cy = (CX_W'(carve_nb.ny) << 1) + CX_W'(2);
        carve_wx = (CX_W'(ci_reg) << 1) + CX_W'(2);
        carve_wy = (CX_W'(cj_reg) << 1) + CX_W'(2);
        case (carve_dir)
            DIR_UP:    carve_wy = carve_wy - 1'b1;
            DIR_DOWN:  carve_wy = carve_wy + 1'b1;
            DIR_LEFT:  carve_wx = carve_wx - 1'b1;
            DIR_RIGHT: carve_wx = carve_wx + 1'b1;
            default:   carve_wx = carve_wx;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        res_valid_next = res_valid_reg;
        res_data_next  = res_data_reg;
        r2_next        = r2_reg;
        pick_next      = pick_reg;
        ci_next        = ci_reg;
        cj_next        = cj_reg;
        scan_next      = scan_reg;
        inb_prev_next  = inb_prev_reg;
        open_next      = open_reg;
        clr_next       = clr_reg;
        shift_rd_next  = shift_rd_reg;
        shift_wa_next  = shift_wa_reg;
        shift_wv_next  = shift_wv_reg;
        pend_next      = pend_reg;

        div_start    = 1'b0;
        div_dividend = r2_reg;
        div_divisor  = '0;

        list_we    = 1'b0;
        list_waddr = '0;
        list_wdata = '0;
        list_raddr = pick_reg;
        vis_we     = 1'b0;
        vis_waddr  = '0;
        vis_wdata  = 1'b0;
        vis_raddr  = vis_addr(scan_nb.nx, scan_nb.ny);

        if (res.ready)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    r2_next = cmd.data.direction_random;
                    if (cmd.data.action == ACT_START)
                    begin
                        clr_next   = AW'(CELL_TOTAL - 1);
                        state_next = S_CLEAR;
                    end
                    else if (count_reg == '0)
                    begin
                        pend_next          = '0;
                        pend_next.done_res = 1'b1;
                        state_next         = S_EMIT;
                    end
                    else
                    begin
                        div_start    = 1'b1;
                        div_dividend = cmd.data.pick_random;
                        div_divisor  = count_reg;
                        state_next   = S_PICK;
                    end
                end
            end
            S_CLEAR:
            begin
                // Sweep downward so that the corner cell is marked on the last write.
                vis_we    = 1'b1;
                vis_waddr = clr_reg;
                vis_wdata = (clr_reg == '0);
                if (clr_reg == '0)
                begin
                    list_we                 = 1'b1;
                    list_waddr              = '0;
                    list_wdata              = '0;
                    count_next              = CNT_W'(1);
                    pend_next               = '0;
                    pend_next.frontier_size = SIZE_W'(1);
                    state_next              = S_EMIT;
                end
                else
                begin
                    clr_next = clr_reg - 1'b1;
                end
            end
            S_PICK:
            begin
                if (div_stat.done)
                begin
                    pick_next  = div_rem[AW-1:0];
                    state_next = S_LIST_RD;
                end
            end
            S_LIST_RD:
            begin
                list_raddr = pick_reg;
                state_next = S_CELL;
            end
            S_CELL:
            begin
                ci_next    = list_rdata_reg[CW-1:0];
                cj_next    = list_rdata_reg[EW-1:CW];
                scan_next  = '0;
                open_next  = '0;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                // Probe neighbour k while judging neighbour k-1 from the registered read.
                inb_prev_next = scan_nb.inb;
                scan_next     = scan_reg + 1'b1;
                if (scan_reg != '0)
                begin
                    open_next[scan_prev] = inb_prev_reg && !vis_rdata_reg;
                end
                if (scan_reg == SCAN_END)
                begin
                    if (open_next != '0)
                    begin
                        div_start    = 1'b1;
                        div_dividend = r2_reg;
                        div_divisor  = CNT_W'($countones(open_next));
                        state_next   = S_DIR;
                    end
                    else
                    begin
                        shift_rd_next = CNT_W'(pick_reg) + 1'b1;
                        shift_wv_next = 1'b0;
                        state_next    = S_SHIFT;
                    end
                end
            end
            S_DIR:
            begin
                if (div_stat.done)
                begin
                    state_next = S_CARVE;
                end
            end
            S_CARVE:
            begin
                vis_we    = 1'b1;
                vis_waddr = vis_addr(carve_nb.nx, carve_nb.ny);
                vis_wdata = 1'b1;
                if (count_reg < CNT_FULL)
                begin
                    list_we    = 1'b1;
                    list_waddr = count_reg[AW-1:0];
                    list_wdata = {carve_nb.ny, carve_nb.nx};
                    count_next = count_reg + 1'b1;
                end
                pend_next               = '0;
                pend_next.carved        = 1'b1;
                pend_next.cell_x        = carve_cx[COORD_W-1:0];
                pend_next.cell_y        = carve_cy[COORD_W-1:0];
                pend_next.wall_x        = carve_wx[COORD_W-1:0];
                pend_next.wall_y        = carve_wy[COORD_W-1:0];
                pend_next.done_res      = (count_next == '0);
                pend_next.frontier_size = SIZE_W'(count_next);
                state_next              = S_EMIT;
            end
            S_SHIFT:
            begin
                if (shift_wv_reg)
                begin
                    list_we    = 1'b1;
                    list_waddr = shift_wa_reg;
                    list_wdata = list_rdata_reg;
                end
                if (shift_rd_reg < count_reg)
                begin
                    list_raddr    = shift_rd_reg[AW-1:0];
                    shift_rd_next = shift_rd_reg + 1'b1;
                    shift_wa_next = AW'(shift_rd_reg - 1'b1);
                    shift_wv_next = 1'b1;
                end
                else
                begin
                    shift_wv_next = 1'b0;
                    if (!shift_wv_reg)
                    begin
                        count_next              = count_reg - 1'b1;
                        pend_next               = '0;
                        pend_next.removed       = 1'b1;
                        pend_next.done_res      = (count_reg == CNT_W'(1));
                        pend_next.frontier_size = SIZE_W'(count_reg - 1'b1);
                        state_next              = S_EMIT;
                    end
                end
            end
            S_EMIT:
            begin
                if (!res_valid_reg || res.ready)
                begin
                    res_data_next  = pend_reg;
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r2_reg       <= r2_next;
        pick_reg     <= pick_next;
        ci_reg       <= ci_next;
        cj_reg       <= cj_next;
        scan_reg     <= scan_next;
        inb_prev_reg <= inb_prev_next;
        open_reg     <= open_next;
        clr_reg      <= clr_next;
        shift_rd_reg <= shift_rd_next;
        shift_wa_reg <= shift_wa_next;
        shift_wv_reg <= shift_wv_next;
        pend_reg     <= pend_next;
        res_data_reg <= res_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (list_we)
        begin
            list_mem[list_waddr] <= list_wdata;
        end
        list_rdata_reg <= list_mem[list_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (vis_we)
        begin
            vis_mem[vis_waddr] <= vis_wdata;
        end
        vis_rdata_reg <= vis_mem[vis_raddr];
    end

    assign cmd.ready = (state_reg == S_IDLE);
    assign res.valid = res_valid_reg;
    assign res.data  = res_data_reg;

    `PMC_ASSERT_NEVER(a_count_in_range, count_reg > CNT_FULL)
    `PMC_ASSERT_NEVER(a_idle_unit_free, state_reg == S_IDLE && div_stat.busy)
    `PMC_ASSERT_NEXT(a_carve_grows, state_reg == S_CARVE, count_reg == $past(count_reg) + 1'b1)

endmodule
